[hdl/assert_macros.svh]
// Assertion shorthands for the port-level checker in hdl/rrw_checker.sv.
// No dependencies; take in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while reset is low.
`define RRW_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrw assertion failed");

// Next-cycle implication, sampled on the rising edge, off while reset is low.
`define RRW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrw assertion failed");

`endif

[hdl/rrw_pkg.sv]
// Shared types and codes for the reliable receive window.
// No dependencies.
`timescale 1ns / 1ps

package rrw_pkg;

  localparam int IdW = 16;

  typedef enum logic [2:0] {
    RRW_NEW   = 3'd0,
    RRW_UNREL = 3'd1,
    RRW_BELOW = 3'd2,
    RRW_ABOVE = 3'd3,
    RRW_DUP   = 3'd4,
    RRW_FAR   = 3'd5
  } rrw_status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MULQ,
    ST_MULR,
    ST_READ,
    ST_LOOK,
    ST_WALK,
    ST_WCHK,
    ST_DONE
  } rrw_state_e;

  typedef struct packed {
    logic           valid;
    logic [IdW-1:0] id;
  } rrw_slot_t;

  localparam int SlotW = $bits(rrw_slot_t);

  // a is after b in wrapping order: (a - b) mod 2^16 in 1..0x7FFF
  function automatic logic serial_after(input logic [IdW-1:0] a,
                                        input logic [IdW-1:0] b);
    logic [IdW-1:0] d;
    d = a - b;
    return (d != '0) && !d[IdW-1];
  endfunction

endpackage

[hdl/reliable_receive_window.sv]
// Top level of the reliable receive window (duplicate and range filter).
// Depends on rrw_pkg and rrw_ram.
`timescale 1ns / 1ps

// Usage
// - Slave stream: one beat per received message. tdata[15:0] holds the
//   reliable ID, tuser[0] the reliable flag (0 passes unchecked).
// - Master stream: one beat per input beat, in order. tuser[0] is deliver,
//   tuser[3:1] the status code, tdata[15:0] the next expected ID and
//   tdata[31:16] the oldest missing ID, both as left by that message.
// - Slot index is ID mod WINDOW_SIZE, formed by a reciprocal multiply and a
//   back-multiply (states MULQ and MULR); the slot table is a single RAM with
//   a registered read, used for the lookup, the write and the slot checks of
//   the oldest walk.
// - Path from input beat to result beat: an unreliable beat goes straight to
//   the output; a reliable one passes the reciprocal and back-multiply, where
//   below and above rejects end; then the slot read and lookup, where
//   duplicate and too-far rejects end; a new ID is written, then the oldest
//   walk skips IDs below the window and checks slots until next or a gap.
// - One message is in work at a time; s_axis_tready is high only while the
//   sequencer is idle. A finished result sits in the output register, so
//   the next beat is taken while the receiver stalls; the sequencer waits
//   only when a second result is ready and the register is still full.
// - Reset: next and oldest clear to 0, then a clearing pass writes every
//   slot invalid, during which s_axis_tready stays low.

module reliable_receive_window
  import rrw_pkg::*;
#(
  parameter int WINDOW_SIZE = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] reliable_id
  input  logic [0:0]  s_axis_tuser,   // [0] is_reliable
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] next_expected, [31:16] oldest_missing
  output logic [3:0]  m_axis_tuser    // [0] deliver, [3:1] status
);

  localparam int AW = $clog2(WINDOW_SIZE);
  // Reciprocal for ID / WINDOW_SIZE, exact for every 16-bit ID
  localparam int SftS = IdW + AW;
  localparam int MulKInt = ((2 ** SftS) + WINDOW_SIZE - 1) / WINDOW_SIZE;
  localparam logic [17:0] MulK = 18'(MulKInt);
  localparam logic [IdW-1:0] WinId = IdW'(WINDOW_SIZE);
  localparam logic [AW-1:0] LastSlot = AW'(WINDOW_SIZE - 1);

  rrw_state_e state_q, state_d;

  logic [AW-1:0]  clr_cnt_q, clr_cnt_d;
  logic [IdW-1:0] id_q, id_d;
  logic [IdW-1:0] quot_q, quot_d;
  logic [AW-1:0]  slot_q, slot_d;
  rrw_status_e    status_q, status_d;
  logic [IdW-1:0] next_q, next_d;
  logic [IdW-1:0] oldest_q, oldest_d;
  logic [AW-1:0]  oslot_q, oslot_d;

  logic           m_valid_q, m_valid_d;
  logic           out_deliver_q, out_deliver_d;
  rrw_status_e    out_status_q, out_status_d;
  logic [IdW-1:0] out_next_q, out_next_d;
  logic [IdW-1:0] out_oldest_q, out_oldest_d;

  // RAM port
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  rrw_slot_t      ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [SlotW-1:0] ram_rdata;
  rrw_slot_t      rd_slot;

  // Slot index arithmetic
  logic [33:0]    prod;
  logic [31:0]    back_prod;
  logic [IdW-1:0] rem;

  // Decision terms
  logic in_fire;
  logic out_load;
  logic is_below, is_above;
  logic is_dup, is_ahead, is_far, take_new;
  logic o_eq_n, o_below, o_hit;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  assign prod      = 34'(id_q) * 34'(MulK);
  assign back_prod = 32'(quot_q) * 32'(WinId);
  assign rem       = id_q - back_prod[IdW-1:0];

  assign is_below = serial_after(next_q - WinId, id_q);
  assign is_above = serial_after(id_q, next_q + WinId);

  assign rd_slot  = rrw_slot_t'(ram_rdata);
  assign is_dup   = rd_slot.valid && (rd_slot.id == id_q);
  assign is_ahead = serial_after(id_q, next_q) || (id_q == next_q);
  assign is_far   = is_ahead && serial_after(id_q, oldest_q + WinId);
  assign take_new = !is_dup && !is_far;

  // Oldest walk: stop at next, skip IDs below the window, else check slot
  assign o_eq_n  = (oldest_q == next_q);
  assign o_below = serial_after(next_q - WinId, oldest_q);
  assign o_hit   = rd_slot.valid && (rd_slot.id == oldest_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == LastSlot) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_d = s_axis_tuser[0] ? ST_MULQ : ST_DONE;
      end
      ST_MULQ: state_d = ST_MULR;
      ST_MULR: begin
        state_d = (status_q == RRW_NEW) ? ST_READ : ST_DONE;
      end
      ST_READ: state_d = ST_LOOK;
      ST_LOOK: state_d = take_new ? ST_WALK : ST_DONE;
      ST_WALK: begin
        if (o_eq_n)        state_d = ST_DONE;
        else if (!o_below) state_d = ST_WCHK;
      end
      ST_WCHK: state_d = o_hit ? ST_WALK : ST_DONE;
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Datapath and RAM controls
  always_comb begin
    clr_cnt_d = clr_cnt_q;
    id_d      = id_q;
    quot_d    = quot_q;
    slot_d    = slot_q;
    status_d  = status_q;
    next_d    = next_q;
    oldest_d  = oldest_q;
    oslot_d   = oslot_q;

    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = '{valid: 1'b1, id: id_q};
    ram_raddr = (state_q == ST_WALK) ? oslot_q : slot_q;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '{valid: 1'b0, id: '1};
        clr_cnt_d = clr_cnt_q + AW'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          id_d     = s_axis_tdata;
          status_d = s_axis_tuser[0] ? RRW_NEW : RRW_UNREL;
        end
      end
      ST_MULQ: begin
        quot_d = IdW'(prod >> SftS);
        if (is_below)      status_d = RRW_BELOW;
        else if (is_above) status_d = RRW_ABOVE;
      end
      ST_MULR: begin
        slot_d = rem[AW-1:0];
      end
      ST_LOOK: begin
        if (is_dup) begin
          status_d = RRW_DUP;
        end else if (is_far) begin
          status_d = RRW_FAR;
        end else begin
          ram_we = 1'b1;
          if (is_ahead) next_d = id_q + IdW'(1);
        end
      end
      // oslot tracks oldest mod WINDOW_SIZE, also across the 16-bit ID wrap
      ST_WALK: begin
        if (!o_eq_n && o_below) begin
          oldest_d = oldest_q + IdW'(1);
          oslot_d  = (oslot_q == LastSlot || oldest_q == '1) ? '0 : oslot_q + AW'(1);
        end
      end
      ST_WCHK: begin
        if (o_hit) begin
          oldest_d = oldest_q + IdW'(1);
          oslot_d  = (oslot_q == LastSlot || oldest_q == '1) ? '0 : oslot_q + AW'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_comb begin
    m_valid_d     = m_valid_q;
    out_deliver_d = out_deliver_q;
    out_status_d  = out_status_q;
    out_next_d    = out_next_q;
    out_oldest_d  = out_oldest_q;
    if (out_load) begin
      m_valid_d     = 1'b1;
      out_deliver_d = (status_q == RRW_NEW) || (status_q == RRW_UNREL);
      out_status_d  = status_q;
      out_next_d    = next_q;
      out_oldest_d  = oldest_q;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      next_q    <= '0;
      oldest_q  <= '0;
      oslot_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      next_q    <= next_d;
      oldest_q  <= oldest_d;
      oslot_q   <= oslot_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q          <= id_d;
    quot_q        <= quot_d;
    slot_q        <= slot_d;
    status_q      <= status_d;
    out_deliver_q <= out_deliver_d;
    out_status_q  <= out_status_d;
    out_next_q    <= out_next_d;
    out_oldest_q  <= out_oldest_d;
  end

  rrw_ram #(
    .WIDTH(SlotW),
    .DEPTH(WINDOW_SIZE)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_oldest_q, out_next_q};
  assign m_axis_tuser  = {out_status_q, out_deliver_q};

endmodule

[hdl/rrw_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module rrw_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/rrw_checker.sv]
// Port-level checks for the reliable receive window, bound to the top level.
// Depends on rrw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrw_port_checks
  import rrw_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser
);

  logic [IdW-1:0] span;
  logic           res_pass;

  // next minus oldest; checked only for oldest never after next (span below 0x8000)
  assign span     = m_axis_tdata[15:0] - m_axis_tdata[31:16];
  assign res_pass = (m_axis_tuser[3:1] == RRW_NEW) || (m_axis_tuser[3:1] == RRW_UNREL);

  `RRW_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `RRW_ASSERT(a_deliver_code, clk_i, rst_ni, m_axis_tvalid, m_axis_tuser[0] == res_pass)
  `RRW_ASSERT(a_oldest_order, clk_i, rst_ni, m_axis_tvalid, !span[IdW-1])
  `RRW_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind reliable_receive_window rrw_port_checks u_rrw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

[tb/sv/rrw_checker.sv]
// Checker for the reliable receive window: watches both streams, predicts each result beat.
// Depends on rrw_pkg for the status codes.
`timescale 1ns / 1ps

module rrw_checker
  import rrw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] in_id_i,
  input  logic        in_rel_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_data_i,   // [15:0] next_expected, [31:16] oldest_missing
  input  logic [3:0]  out_user_i,   // [0] deliver, [3:1] status
  output int          fail_count_o,
  output int          backlog_o,
  output logic [15:0] next_id_o,
  output logic [15:0] oldest_id_o
);

  localparam int          WIN   = 1024;
  localparam logic [15:0] WIN16 = 16'(WIN);

  typedef struct {
    logic           deliver;
    rrw_status_e    status;
    logic [15:0]    next_mark;
    logic [15:0]    oldest_mark;
  } verdict_t;

  logic [15:0] slot_tag  [WIN];
  logic        slot_live [WIN];
  logic [15:0] next_id;
  logic [15:0] oldest_id;
  verdict_t    pending_verdicts [$];

  assign next_id_o   = next_id;
  assign oldest_id_o = oldest_id;

  // wrapping order: a later than b when the 16-bit distance is 1..0x7FFF
  function automatic logic is_later(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] gap;
    gap = a - b;
    return (gap != 16'd0) && (gap < 16'h8000);
  endfunction

  // below the window, or the slot is live and tagged with this very ID
  function automatic logic already_held(input logic [15:0] id);
    int slot;
    slot = int'(id) % WIN;
    if (is_later(next_id - WIN16, id)) return 1'b1;
    return slot_live[slot] && (slot_tag[slot] == id);
  endfunction

  task automatic screen(input logic [15:0] id, input logic rel);
    verdict_t v;
    logic     ahead;
    int       slot;
    slot = int'(id) % WIN;
    if (!rel) begin
      v.status = RRW_UNREL;
    end else if (is_later(next_id - WIN16, id)) begin
      v.status = RRW_BELOW;
    end else if (is_later(id, next_id + WIN16)) begin
      v.status = RRW_ABOVE;
    end else if (already_held(id)) begin
      v.status = RRW_DUP;
    end else begin
      ahead = (id == next_id) || is_later(id, next_id);
      if (ahead && is_later(id, oldest_id + WIN16)) begin
        v.status = RRW_FAR;
      end else begin
        if (ahead) next_id = id + 16'd1;
        slot_tag[slot]  = id;
        slot_live[slot] = 1'b1;
        while (oldest_id != next_id && already_held(oldest_id)) oldest_id = oldest_id + 16'd1;
        v.status = RRW_NEW;
      end
    end
    v.deliver     = (v.status == RRW_NEW) || (v.status == RRW_UNREL);
    v.next_mark   = next_id;
    v.oldest_mark = oldest_id;
    pending_verdicts.push_back(v);
  endtask

  task automatic compare(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_beat();
    verdict_t want;
    if (pending_verdicts.size() == 0) begin
      $error("result beat with nothing outstanding: tdata %h tuser %h", out_data_i, out_user_i);
      fail_count_o++;
    end else begin
      want = pending_verdicts.pop_front();
      compare("deliver", 16'(want.deliver), 16'(out_user_i[0]));
      compare("status", 16'(want.status), 16'(out_user_i[3:1]));
      compare("next_expected", want.next_mark, out_data_i[15:0]);
      compare("oldest_missing", want.oldest_mark, out_data_i[31:16]);
    end
  endtask

  // results retire before the same edge's input is screened; no result beat comes in the same cycle as its input beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN; i++) begin
        slot_tag[i]  = 16'hFFFF;
        slot_live[i] = 1'b0;
      end
      next_id      = 16'd0;
      oldest_id    = 16'd0;
      fail_count_o = 0;
      pending_verdicts.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_beat();
      if (in_valid_i && in_ready_i) screen(in_id_i, in_rel_i);
    end
    backlog_o = pending_verdicts.size();
  end

endmodule

[tb/sv/testbench.sv]
// Top of the reliable receive window bench: clock, reset, message stimulus and verdict.
// Depends on rrw_pkg, reliable_receive_window and rrw_checker.
`timescale 1ns / 1ps

module testbench;
  import rrw_pkg::*;

  localparam logic [15:0] WIN16        = 16'd1024;
  localparam int          RANDOM_BEATS = 1730;
  localparam int          CALM_BEATS   = 250;   // tail of the run with no idling at all
  localparam int          HOLD_AT      = 300;   // beat count that triggers the long receiver stall
  localparam int          HOLD_CYCLES  = 600;
  localparam int          STALL_LIMIT  = 20000; // watchdog limit, well above the longest walk

  // how the next message ID is chosen, relative to the predicted next/oldest
  typedef enum {
    PICK_UNREL,
    PICK_FIXED,
    PICK_FRESH,
    PICK_FILL,
    PICK_DUP,
    PICK_JUMP,
    PICK_BELOW,
    PICK_ABOVE,
    PICK_FAR,
    PICK_HALF_LO,
    PICK_HALF_HI,
    PICK_NOISE
  } pick_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = 16'd0;   // [15:0] reliable_id
  logic [0:0]  s_axis_tuser = 1'b0;    // [0] is_reliable
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [15:0] next_expected, [31:16] oldest_missing
  logic [3:0]  m_axis_tuser;           // [0] deliver, [3:1] status

  int          fails;
  int          backlog;
  logic [15:0] exp_next;
  logic [15:0] exp_oldest;
  int          sent = 0;
  logic        calm = 1'b0;
  int          stall = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  reliable_receive_window u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  rrw_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_id_i      (s_axis_tdata),
    .in_rel_i     (s_axis_tuser[0]),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_user_i   (m_axis_tuser),
    .fail_count_o (fails),
    .backlog_o    (backlog),
    .next_id_o    (exp_next),
    .oldest_id_o  (exp_oldest)
  );

  // One message beat. The ID is picked at the falling edge, after the checker has
  // absorbed every earlier accepted beat, so the predicted next/oldest are current.
  // A random idle gap may come first, except in the calm tail.
  task automatic offer(input pick_e kind, input logic [15:0] fix_id);
    logic [15:0] n;
    logic [15:0] o;
    logic [15:0] id;
    logic        rel;
    int          gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    n   = exp_next;
    o   = exp_oldest;
    rel = 1'b1;
    case (kind)
      PICK_UNREL: begin
        id  = fix_id;
        rel = 1'b0;
      end
      PICK_FIXED:   id = fix_id;
      PICK_FRESH:   id = n + 16'($urandom_range(0, 12));     // at or just past next
      PICK_FILL:    id = o + 16'($urandom_range(0, 7));      // gaps right above oldest
      PICK_DUP:     id = n - 16'($urandom_range(1, 48));     // recent, mostly already seen
      PICK_JUMP:    id = o + WIN16 - 16'($urandom_range(0, 2)); // far edge, drags the window
      PICK_BELOW:   id = n - WIN16 - 16'($urandom_range(1, 300));
      PICK_ABOVE:   id = n + WIN16 + 16'($urandom_range(1, 300));
      PICK_FAR:     id = o + WIN16 + 16'($urandom_range(1, 8));
      PICK_HALF_LO: id = n - WIN16 + 16'h8000;  // exactly half-way from the window floor
      PICK_HALF_HI: id = n + WIN16 + 16'h8000;  // exactly half-way from the range top
      default: begin
        id  = 16'($urandom);
        rel = 1'($urandom);
      end
    endcase
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = id;
    s_axis_tuser  = rel;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  // Stimulus and verdict
  initial begin
    int    roll;
    pick_e kind;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes, an offer aimed at each status, ID 0xFFFF as a plain ID, half-way distances
    offer(PICK_UNREL, 16'hFFFF);
    offer(PICK_UNREL, 16'h0000);
    offer(PICK_FIXED, 16'h0000);   // new
    offer(PICK_FIXED, 16'h0000);   // duplicate
    offer(PICK_FIXED, 16'hFFFF);   // behind next but inside the window: accepted
    offer(PICK_FIXED, 16'hFFFF);   // duplicate of the all-ones ID
    offer(PICK_ABOVE, 16'h0000);
    offer(PICK_FRESH, 16'h0000);
    offer(PICK_FRESH, 16'h0000);   // likely opens a gap, oldest stays behind
    offer(PICK_FAR, 16'h0000);
    offer(PICK_JUMP, 16'h0000);
    offer(PICK_JUMP, 16'h0000);    // second jump pushes oldest over the floor
    offer(PICK_BELOW, 16'h0000);
    offer(PICK_HALF_LO, 16'h0000);
    offer(PICK_HALF_HI, 16'h0000);
    offer(PICK_FILL, 16'h0000);
    offer(PICK_FILL, 16'h0000);
    offer(PICK_FILL, 16'h0000);
    offer(PICK_DUP, 16'h0000);
    offer(PICK_NOISE, 16'h0000);

    // random: mostly in-window traffic, jumps to sweep the whole ID space and wrap next
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      calm = (i >= RANDOM_BEATS - CALM_BEATS);
      if (i == RANDOM_BEATS / 2) begin
        // sender goes quiet until every outstanding result has drained
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (backlog != 0) @(negedge clk);
      end
      roll = $urandom_range(0, 99);
      if (roll < 30)      kind = PICK_FRESH;
      else if (roll < 48) kind = PICK_FILL;
      else if (roll < 58) kind = PICK_DUP;
      else if (roll < 66) kind = PICK_JUMP;
      else if (roll < 70) kind = PICK_BELOW;
      else if (roll < 74) kind = PICK_ABOVE;
      else if (roll < 79) kind = PICK_FAR;
      else if (roll < 81) kind = (roll[0]) ? PICK_HALF_HI : PICK_HALF_LO;
      else if (roll < 89) kind = PICK_UNREL;
      else                kind = PICK_NOISE;
      offer(kind, 16'($urandom));
    end

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (backlog != 0) @(negedge clk);
    // room for a stray extra beat to show up
    repeat (40) @(negedge clk);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver: short random stalls, one long hold-off while the sender keeps
  // offering (fills the output register and the sequencer), none in the calm tail.
  initial begin
    int   hold;
    logic held_once;
    hold      = 0;
    held_once = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!held_once && sent >= HOLD_AT) begin
        hold      = HOLD_CYCLES;
        held_once = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 3);
      end
      m_axis_tready = (hold == 0);
    end
  end

  // Watchdog: cycles without any beat on either side; covers the clearing pass too
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall <= 0;
    end else begin
      stall <= stall + 1;
    end
    if (stall >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

[files.f]
+incdir+hdl
hdl/rrw_pkg.sv
hdl/rrw_ram.sv
hdl/reliable_receive_window.sv
hdl/rrw_checker.sv
tb/sv/rrw_checker.sv
tb/sv/testbench.sv
